// ----- src/assert_macros.svh -----
// Assertion macros shared by the encoder RTL.
// Each macro samples on posedge clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define B64E_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define B64E_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define B64E_ASSERT(label, prop, msg)
`define B64E_ASSERT_NEVER(label, expr, msg)
`endif
`endif

// ----- src/b64e_pkg.sv -----
// Types, constants and the symbol-to-character map of the base64 encoder.
// No dependencies.
package b64e_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    typedef enum logic [1:0]
    {
        PHASE_FIRST  = 2'd0,
        PHASE_SECOND = 2'd1,
        PHASE_THIRD  = 2'd2,
        PHASE_UNUSED = 2'd3
    } phase_t;

    // One encode job: up to two 6-bit symbols, then '=' up to count characters.
    typedef struct packed
    {
        logic [1:0][5:0] sym;
        logic [1:0]      nsym;
        logic [2:0]      count;
        logic            last;
    } job_t;

    function automatic logic [7:0] b64_char(input logic [5:0] s);
        logic [7:0] c;
        if (s < 6'd26)
            c = 8'h41 + {2'b00, s};
        else if (s < 6'd52)
            c = 8'h61 + {2'b00, s} - 8'd26;
        else if (s < 6'd62)
            c = 8'h30 + {2'b00, s} - 8'd52;
        else if (s == 6'd62)
            c = 8'h2B;
        else
            c = 8'h2F;
        return c;
    endfunction

endpackage

// ----- src/b64e_byte_if.sv -----
// Byte channel: valid/ready handshake with one raw byte and a final flag.
// Depends on nothing.
interface b64e_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

// ----- src/b64e_char_if.sv -----
// Character channel: valid/ready handshake with one base64 character.
// Depends on nothing.
interface b64e_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       out_last;

    modport source (output valid, output out_char, output out_last, input ready);
    modport sink   (input valid, input out_char, input out_last, output ready);
endinterface

// ----- src/b64e_front.sv -----
// Front end: takes byte transfers, tracks group phase and leftover bits,
// and builds one job per byte. Depends on b64e_pkg and assert_macros.svh.
`include "assert_macros.svh"
module b64e_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           valid,
    output logic           ready,
    input  logic [7:0]     data_byte,
    input  logic           final_byte,
    input  logic           full,
    output logic           push,
    output b64e_pkg::job_t job
);
    import b64e_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [3:0] left_reg, left_next;

    assign ready = !full;
    assign push  = valid && !full;

    always_comb
    begin
        job        = '0;
        job.last   = final_byte;
        phase_next = phase_reg;
        left_next  = left_reg;
        unique case (phase_reg)
            PHASE_SECOND:
            begin
                job.sym[0] = {left_reg[1:0], data_byte[7:4]};
                job.sym[1] = {data_byte[3:0], 2'b00};
                job.nsym   = final_byte ? 2'd2 : 2'd1;
                job.count  = final_byte ? 3'd3 : 3'd1;
                phase_next = PHASE_THIRD;
                left_next  = data_byte[3:0];
            end
            PHASE_THIRD:
            begin
                job.sym[0] = {left_reg, data_byte[7:6]};
                job.sym[1] = data_byte[5:0];
                job.nsym   = 2'd2;
                job.count  = 3'd2;
                phase_next = PHASE_FIRST;
                left_next  = 4'd0;
            end
            PHASE_FIRST, PHASE_UNUSED:
            begin
                job.sym[0] = data_byte[7:2];
                job.sym[1] = {data_byte[1:0], 4'b0000};
                job.nsym   = final_byte ? 2'd2 : 2'd1;
                job.count  = final_byte ? 3'd4 : 3'd1;
                phase_next = PHASE_SECOND;
                left_next  = {2'b00, data_byte[1:0]};
            end
        endcase
        if (final_byte)
        begin
            phase_next = PHASE_FIRST;
            left_next  = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_FIRST;
            left_reg  <= 4'd0;
        end
        else if (push)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
        end
    end

    `B64E_ASSERT(a_third_clears, (push && phase_reg == PHASE_THIRD) |=> (left_reg == 4'd0 && phase_reg == PHASE_FIRST), "third byte must close the group")
    `B64E_ASSERT(a_final_resets, (push && final_byte) |=> (phase_reg == PHASE_FIRST && left_reg == 4'd0), "final byte must return to group start")
endmodule

// ----- src/b64e_queue.sv -----
// Short job queue between front and back end.
// Depends on b64e_pkg and assert_macros.svh.
`include "assert_macros.svh"
module b64e_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  b64e_pkg::job_t wr_job,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output b64e_pkg::job_t rd_job
);
    import b64e_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full   = (cnt_reg == CNT_W'(DEPTH));
    assign empty  = (cnt_reg == '0);
    assign rd_job = mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    `B64E_ASSERT_NEVER(a_no_overflow, push && full, "push into full queue")
    `B64E_ASSERT_NEVER(a_no_underflow, pop && empty, "pop from empty queue")
endmodule

// ----- src/b64e_back.sv -----
// Back end: drains jobs one character per cycle, unless ready stalls it, into the output register.
// Depends on b64e_pkg and assert_macros.svh.
`include "assert_macros.svh"
module b64e_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           empty,
    input  b64e_pkg::job_t job,
    output logic           pop,
    output logic           valid,
    input  logic           ready,
    output logic [7:0]     out_char,
    output logic           out_last
);
    import b64e_pkg::*;

    logic [1:0] idx_reg;
    logic       valid_reg;
    logic [7:0] char_reg;
    logic       last_reg;
    logic       advance;
    logic       take;
    logic       job_done;
    logic [7:0] char_next;

    assign advance  = !valid_reg || ready;
    assign take     = advance && !empty;
    assign job_done = ({1'b0, idx_reg} == job.count - 3'd1);
    assign pop      = take && job_done;
    assign char_next = (idx_reg < job.nsym) ? b64_char(job.sym[idx_reg[0]]) : PAD_CHAR;

    assign valid    = valid_reg;
    assign out_char = char_reg;
    assign out_last = last_reg;

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            char_reg <= char_next;
            last_reg <= job.last && job_done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            if (advance)
                valid_reg <= !empty;
            if (take)
                idx_reg <= job_done ? 2'd0 : idx_reg + 2'd1;
        end
    end

    `B64E_ASSERT(a_mid_job_held, (idx_reg != 2'd0) |-> !empty, "job index set with no job queued")
endmodule

// ----- src/base64_stream_encoder_unit.sv -----
// Top level of the streaming base64 encoder: front end, job queue, back end.
// Depends on b64e_pkg, b64e_byte_if, b64e_char_if and the b64e_* modules.
//
//  channel   dir  payload                         transfer
//  data_ch   in   data_byte[7:0], final_byte      valid && ready
//  char_ch   out  out_char[7:0], out_last         valid && ready
//
// A byte is taken whenever the job queue has room; it yields 1 to 4 characters,
// which the back end sends one per cycle while char_ch is not stalled, four characters
// per three bytes on long messages, through the single output character register.
// The first character of a byte goes through the job queue, then that output register.
// Reset clears phase, queue and output valid; no clearing pass.
// Output stalls back up through the queue to data_ch.ready.
module base64_stream_encoder_unit
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    b64e_byte_if.sink   data_ch,
    b64e_char_if.source char_ch
);
    import b64e_pkg::*;

    job_t wr_job;
    job_t rd_job;
    logic push;
    logic pop;
    logic full;
    logic empty;

    b64e_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (data_ch.valid),
        .ready      (data_ch.ready),
        .data_byte  (data_ch.data_byte),
        .final_byte (data_ch.final_byte),
        .full       (full),
        .push       (push),
        .job        (wr_job)
    );

    b64e_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (wr_job),
        .full   (full),
        .pop    (pop),
        .empty  (empty),
        .rd_job (rd_job)
    );

    b64e_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .job      (rd_job),
        .pop      (pop),
        .valid    (char_ch.valid),
        .ready    (char_ch.ready),
        .out_char (char_ch.out_char),
        .out_last (char_ch.out_last)
    );
endmodule
